FILE: rtl/core/srtc_pkg.sv
// ----------------------------------------------------------------------------
// srtc_pkg
// Shared types and constants of the stepper ramp and traverse controller.
// ----------------------------------------------------------------------------
`default_nettype none

package srtc_pkg;

  localparam int unsigned CFG_AW     = 5;
  localparam int unsigned CFG_DW     = 32;
  localparam int unsigned IN_DW      = 24;
  localparam int unsigned OUT_DW     = 80;

  localparam int unsigned DIV_W      = 20;
  localparam int unsigned DVS_W      = 16;
  localparam int unsigned DIV_STEPS  = DIV_W;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam logic [DIV_W-1:0] PERIOD_NUM = 20'd1000000;
  localparam logic [15:0]      MIN_MAG    = 16'd16;
  localparam logic [15:0]      MOVE_MAG   = 16'd15;
  localparam logic [15:0]      POS_SPOOL  = 16'd2;

  localparam logic [7:0]  RST_HOLDING = 8'd0;
  localparam logic [7:0]  RST_MIN     = 8'd127;
  localparam logic [7:0]  RST_MAX     = 8'd255;
  localparam logic [7:0]  RST_DIV     = 8'd255;
  localparam logic [7:0]  RST_ACCEL   = 8'd8;
  localparam logic [15:0] RST_LOW     = 16'd200;
  localparam logic [15:0] RST_HIGH    = 16'd1000;
  localparam logic [15:0] RST_SPP     = 16'd0;

  typedef enum logic [1:0] {
    K_TICK   = 2'd0,
    K_STEP   = 2'd1,
    K_TARGET = 2'd2,
    K_RESET  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_LOW  = 2'd0,
    PH_HIGH = 2'd1,
    PH_HOME = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    R_HOLDING = 3'd0,
    R_MIN     = 3'd1,
    R_MAX     = 3'd2,
    R_DIV     = 3'd3,
    R_ACCEL   = 3'd4,
    R_LOW     = 3'd5,
    R_HIGH    = 3'd6,
    R_SPP     = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  holding_torque;
    logic [7:0]  min_torque;
    logic [7:0]  max_torque;
    logic [7:0]  torque_divisor;
    logic [7:0]  accel_step;
    logic [15:0] low_position;
    logic [15:0] high_position;
    logic [15:0] steps_per_position;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/stepper_ramp_traverse_controller_core.sv
// ----------------------------------------------------------------------------
// stepper_ramp_traverse_controller_core
// Stepper speed ramp with homing, traverse reversal and torque selection.
//
// The input stream carries one event per item: tuser holds the kind
// (acceleration tick, step event, new target, reset command) and tdata the
// home switch level and the signed target speed. Every item yields exactly
// one result item on the output stream with the speed, step period,
// direction, torque, driver write flags, position, phase and target.
// An item passes from acceptance to a valid result through the position,
// limit and ramp states of state update, a start state, the bit-serial
// dividers that form the step period and the dynamic torque (20 quotient bits
// and a done flag), a torque state and an output state. Only one item is in
// flight: a new item is taken only once the last has left the output state.
// The result sits in an output register; the next item is accepted while it
// waits, and that item then holds in its output state until the slot is free.
// Synchronous reset restores the register defaults, clears speed, target,
// counters and torque, and puts the traverse in the seeking home phase.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_ramp_traverse_controller_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // [0] home_closed, [16:1] new_target, [23:17] zero
  input  logic [srtc_pkg::IN_DW-1:0]   in_tdata,
  // [1:0] kind
  input  logic [1:0]                   in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [15:0] motor_speed, [31:16] step_period, [32] direction, [40:33] torque,
  // [41] torque_write, [42] control_write, [58:43] position_count,
  // [60:59] homing_phase, [61] step_pulse, [77:62] target_speed, [79:78] zero
  output logic [srtc_pkg::OUT_DW-1:0]  out_tdata,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [srtc_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [srtc_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [srtc_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import srtc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_POS, S_LIMIT, S_RAMP, S_START, S_DIV, S_TORQ, S_OUT
  } state_t;

  function automatic logic [15:0] mag16(input logic signed [15:0] v);
    mag16 = v[15] ? 16'(-v) : 16'(v);
  endfunction

  function automatic logic signed [15:0] neg16(input logic signed [15:0] v);
    neg16 = (v == -16'sd32768) ? 16'sd32767 : -v;
  endfunction

  cfg_t cfg;

  state_t              state_r, state_nxt;
  kind_t               kind_r, kind_nxt;
  logic                home_r, home_nxt;
  logic signed [15:0]  tgt_r, tgt_nxt;
  logic signed [15:0]  speed_r, speed_nxt;
  logic signed [15:0]  goal_r, goal_nxt;
  logic [15:0]         step_r, step_nxt;
  logic [15:0]         pos_r, pos_nxt;
  phase_t              phase_r, phase_nxt;
  logic [7:0]          torque_r, torque_nxt;
  logic [7:0]          tlast_r, tlast_nxt;
  logic                lim_r, lim_nxt;
  logic                chg_r, chg_nxt;
  logic                tw_r, tw_nxt;
  logic                cw_r, cw_nxt;
  logic                pulse_r, pulse_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DW-1:0]   out_data_r, out_data_nxt;

  logic                div_start;
  logic                per_done;
  logic                tq_done;
  logic [DIV_W-1:0]    per_q;
  logic [DIV_W-1:0]    tq_q;
  logic [15:0]         speed_mag;
  logic [15:0]         per_dvs;
  logic signed [16:0]  gap;
  logic [16:0]         gap_mag;
  logic [DIV_W:0]      tq_sum;
  logic [7:0]          tq_new;

  srtc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  assign speed_mag = mag16(speed_r);
  assign per_dvs   = (speed_mag < MIN_MAG) ? MIN_MAG : speed_mag;

  srtc_div u_per_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (PERIOD_NUM),
    .divisor  (per_dvs),
    .done     (per_done),
    .quotient (per_q)
  );

  srtc_div u_tq_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({{(DIV_W-16){1'b0}}, speed_mag}),
    .divisor  ({8'd0, cfg.torque_divisor}),
    .done     (tq_done),
    .quotient (tq_q)
  );

  assign gap     = {goal_r[15], goal_r} - {speed_r[15], speed_r};
  assign gap_mag = gap[16] ? 17'(-gap) : 17'(gap);
  assign tq_sum  = {1'b0, tq_q} + {{(DIV_W-7){1'b0}}, cfg.min_torque};

  always_comb begin
    if (speed_mag <= MIN_MAG) begin
      tq_new = cfg.holding_torque;
    end else if (cfg.torque_divisor == 8'd0) begin
      tq_new = cfg.max_torque;
    end else if (tq_sum > {{(DIV_W-7){1'b0}}, cfg.max_torque}) begin
      tq_new = cfg.max_torque;
    end else begin
      tq_new = tq_sum[7:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    home_nxt      = home_r;
    tgt_nxt       = tgt_r;
    speed_nxt     = speed_r;
    goal_nxt      = goal_r;
    step_nxt      = step_r;
    pos_nxt       = pos_r;
    phase_nxt     = phase_r;
    torque_nxt    = torque_r;
    tlast_nxt     = tlast_r;
    lim_nxt       = lim_r;
    chg_nxt       = chg_r;
    tw_nxt        = tw_r;
    cw_nxt        = cw_r;
    pulse_nxt     = pulse_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt  = kind_t'(in_tuser);
          home_nxt  = in_tdata[0];
          tgt_nxt   = in_tdata[16:1];
          lim_nxt   = 1'b0;
          chg_nxt   = 1'b0;
          tw_nxt    = 1'b0;
          cw_nxt    = 1'b0;
          pulse_nxt = 1'b0;
          state_nxt = S_POS;
        end
      end
      S_POS: begin
        case (kind_r)
          K_TICK: begin
            if (cfg.steps_per_position == 16'd0) begin
              if (home_r) begin
                if (pos_r == 16'd0) begin
                  pos_nxt = POS_SPOOL;
                end
              end else begin
                pos_nxt = 16'd0;
              end
            end else if (phase_r == PH_HOME) begin
              if (home_r && (mag16(goal_r) > MOVE_MAG)) begin
                phase_nxt = PH_HIGH;
                step_nxt  = 16'd0;
                pos_nxt   = 16'd0;
                goal_nxt  = neg16(goal_r);
              end
            end else begin
              lim_nxt = 1'b1;
              if (step_r > cfg.steps_per_position) begin
                step_nxt = 16'd0;
                if (!goal_r[15] && (goal_r != 16'sd0)) begin
                  pos_nxt = pos_r + 16'd1;
                end else if (goal_r[15] && (pos_r != 16'd0)) begin
                  pos_nxt = pos_r - 16'd1;
                end
              end
            end
          end
          K_STEP: begin
            if (speed_mag > MOVE_MAG) begin
              pulse_nxt = 1'b1;
              step_nxt  = step_r + 16'd1;
            end
          end
          K_TARGET: begin
            goal_nxt = tgt_r;
          end
          K_RESET: begin
            goal_nxt   = 16'sd0;
            speed_nxt  = 16'sd0;
            torque_nxt = cfg.holding_torque;
            cw_nxt     = 1'b1;
            if (cfg.steps_per_position != 16'd0) begin
              step_nxt  = 16'd0;
              pos_nxt   = 16'd0;
              phase_nxt = PH_HOME;
            end
          end
          default: begin
            goal_nxt = goal_r;
          end
        endcase
        state_nxt = S_LIMIT;
      end
      S_LIMIT: begin
        if (lim_r) begin
          if ((phase_r == PH_HIGH) && (pos_r > cfg.high_position)) begin
            phase_nxt = PH_LOW;
            goal_nxt  = neg16(goal_r);
          end else if ((phase_r == PH_LOW) && (pos_r < cfg.low_position)) begin
            phase_nxt = PH_HIGH;
            goal_nxt  = neg16(goal_r);
          end
        end
        state_nxt = S_RAMP;
      end
      S_RAMP: begin
        if ((kind_r == K_TICK) && (gap != 17'sd0) && (cfg.accel_step != 8'd0)) begin
          chg_nxt = 1'b1;
          if (gap_mag <= {9'd0, cfg.accel_step}) begin
            speed_nxt = goal_r;
          end else if (gap[16]) begin
            speed_nxt = speed_r - $signed({8'd0, cfg.accel_step});
          end else begin
            speed_nxt = speed_r + $signed({8'd0, cfg.accel_step});
          end
        end
        state_nxt = S_START;
      end
      S_START: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (per_done) begin
          state_nxt = S_TORQ;
        end
      end
      S_TORQ: begin
        if (chg_r) begin
          torque_nxt = tq_new;
          if (tq_new != tlast_r) begin
            if ((tq_new == 8'd0) || (tlast_r == 8'd0)) begin
              cw_nxt = 1'b1;
            end
            tlast_nxt = tq_new;
            tw_nxt    = 1'b1;
          end
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt = {2'b00, goal_r, pulse_r, phase_r, pos_r, cw_r, tw_r,
                          torque_r, (!speed_r[15] && (speed_r != 16'sd0)),
                          per_q[15:0], speed_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      speed_r     <= 16'sd0;
      goal_r      <= 16'sd0;
      step_r      <= 16'd0;
      pos_r       <= 16'd0;
      phase_r     <= PH_HOME;
      torque_r    <= 8'd0;
      tlast_r     <= 8'd1;
      lim_r       <= 1'b0;
      chg_r       <= 1'b0;
      tw_r        <= 1'b0;
      cw_r        <= 1'b0;
      pulse_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      speed_r     <= speed_nxt;
      goal_r      <= goal_nxt;
      step_r      <= step_nxt;
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      torque_r    <= torque_nxt;
      tlast_r     <= tlast_nxt;
      lim_r       <= lim_nxt;
      chg_r       <= chg_nxt;
      tw_r        <= tw_nxt;
      cw_r        <= cw_nxt;
      pulse_r     <= pulse_nxt;
      out_valid_r <= out_valid_nxt;
      kind_r      <= kind_nxt;
      home_r      <= home_nxt;
      tgt_r       <= tgt_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_pready = 1'b1;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted while one is in flight");

  a_div_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (per_done || tq_done) |-> (per_done && tq_done && (state_r == S_DIV)))
    else $error("divider finished outside the divide phase");

  a_tw_track: assert property (@(posedge clk) disable iff (!rst_n)
    tw_r |-> (tlast_r == torque_r))
    else $error("torque write flagged without tracking the new torque");

  a_pulse_kind: assert property (@(posedge clk) disable iff (!rst_n)
    pulse_r |-> (kind_r == K_STEP))
    else $error("step pulse raised for an item that is not a step event");

endmodule

`default_nettype wire

FILE: rtl/core/srtc_div.sv
// ----------------------------------------------------------------------------
// srtc_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module srtc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [srtc_pkg::DIV_W-1:0]  dividend,
  input  logic [srtc_pkg::DVS_W-1:0]  divisor,
  output logic                        done,
  output logic [srtc_pkg::DIV_W-1:0]  quotient
);
  import srtc_pkg::*;

  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DVS_W-1:0]     rem_r, rem_nxt;
  logic [DVS_W-1:0]     dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DVS_W:0]       trial;
  logic [DVS_W:0]       diff;
  logic                 ge;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      quo_r  <= quo_nxt;
      rem_r  <= rem_nxt;
      dvs_r  <= dvs_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

FILE: rtl/core/srtc_regs.sv
// ----------------------------------------------------------------------------
// srtc_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module srtc_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [srtc_pkg::CFG_AW-1:0]  paddr,
  input  logic [srtc_pkg::CFG_DW-1:0]  pwdata,
  output logic [srtc_pkg::CFG_DW-1:0]  prdata,
  output srtc_pkg::cfg_t               cfg
);
  import srtc_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx   = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        R_HOLDING: cfg_nxt.holding_torque     = pwdata[7:0];
        R_MIN:     cfg_nxt.min_torque         = pwdata[7:0];
        R_MAX:     cfg_nxt.max_torque         = pwdata[7:0];
        R_DIV:     cfg_nxt.torque_divisor     = pwdata[7:0];
        R_ACCEL:   cfg_nxt.accel_step         = pwdata[7:0];
        R_LOW:     cfg_nxt.low_position       = pwdata[15:0];
        R_HIGH:    cfg_nxt.high_position      = pwdata[15:0];
        R_SPP:     cfg_nxt.steps_per_position = pwdata[15:0];
        default:   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      R_HOLDING: prdata = {24'd0, cfg_r.holding_torque};
      R_MIN:     prdata = {24'd0, cfg_r.min_torque};
      R_MAX:     prdata = {24'd0, cfg_r.max_torque};
      R_DIV:     prdata = {24'd0, cfg_r.torque_divisor};
      R_ACCEL:   prdata = {24'd0, cfg_r.accel_step};
      R_LOW:     prdata = {16'd0, cfg_r.low_position};
      R_HIGH:    prdata = {16'd0, cfg_r.high_position};
      R_SPP:     prdata = {16'd0, cfg_r.steps_per_position};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.holding_torque     <= RST_HOLDING;
      cfg_r.min_torque         <= RST_MIN;
      cfg_r.max_torque         <= RST_MAX;
      cfg_r.torque_divisor     <= RST_DIV;
      cfg_r.accel_step         <= RST_ACCEL;
      cfg_r.low_position       <= RST_LOW;
      cfg_r.high_position      <= RST_HIGH;
      cfg_r.steps_per_position <= RST_SPP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: tb/stepper_ramp_traverse_controller_core_tb.sv
// ----------------------------------------------------------------------------
// stepper_ramp_traverse_controller_core_tb
// Self-checking testbench for the stepper ramp and traverse controller core.
//
// Event items go in on the input stream and motion results come back on the
// output stream. A scoreboard class keeps its own copy of the speed ramp,
// homing, traverse and torque logic. It works out the expected result of each
// accepted item and compares every returned result with it, field by field.
// A short directed sequence comes first. It is followed by register settings
// that cover spool and traverse modes and the register extremes, each with
// random item streams. The sender works in bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module stepper_ramp_traverse_controller_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srtc_pkg::*;

  typedef struct {
    logic [15:0] speed;
    logic [15:0] period;
    logic        dir;
    logic [7:0]  torque;
    logic        torque_wr;
    logic        control_wr;
    logic [15:0] pos;
    logic [1:0]  phase;
    logic        pulse;
    logic [15:0] goal;
  } motion_t;

  class motion_scoreboard;
    logic [7:0]  hold_tq, min_tq, max_tq, tq_div, accel;
    logic [15:0] low_pos, high_pos, spp;
    int          speed, goal;
    logic [15:0] step_cnt, pos_cnt;
    phase_t      ph;
    logic [7:0]  tq_now, tq_prev;
    motion_t     expected_q[$];
    int          errors, checked, accepted;

    function new();
      hold_tq  = RST_HOLDING;
      min_tq   = RST_MIN;
      max_tq   = RST_MAX;
      tq_div   = RST_DIV;
      accel    = RST_ACCEL;
      low_pos  = RST_LOW;
      high_pos = RST_HIGH;
      spp      = RST_SPP;
      speed    = 0;
      goal     = 0;
      step_cnt = '0;
      pos_cnt  = '0;
      ph       = PH_HOME;
      tq_now   = 8'd0;
      tq_prev  = 8'd1;
      errors   = 0;
      checked  = 0;
      accepted = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [15:0] val);
      case (idx)
        R_HOLDING: hold_tq  = val[7:0];
        R_MIN:     min_tq   = val[7:0];
        R_MAX:     max_tq   = val[7:0];
        R_DIV:     tq_div   = val[7:0];
        R_ACCEL:   accel    = val[7:0];
        R_LOW:     low_pos  = val;
        R_HIGH:    high_pos = val;
        default:   spp      = val;
      endcase
    endfunction

    function int unsigned magnitude(int v);
      return (v < 0) ? -v : v;
    endfunction

    // The most negative target cannot be negated in 16 bits and saturates.
    function int reversed(int v);
      return (v <= -32768) ? 32767 : -v;
    endfunction

    function logic [7:0] torque_for_speed();
      int unsigned m, t;
      m = magnitude(speed);
      if (m <= MIN_MAG) return hold_tq;
      if (tq_div == 8'd0) return max_tq;
      t = m / tq_div + min_tq;
      if (t > max_tq) t = max_tq;
      return t[7:0];
    endfunction

    function void accel_tick(logic home, inout logic tw, inout logic cw);
      int gap, adj, acc;
      adj = 0;
      acc = int'(accel);
      if (spp == 16'd0) begin
        if (home) begin
          if (pos_cnt == 16'd0) pos_cnt = POS_SPOOL;
        end else begin
          pos_cnt = '0;
        end
      end else if (ph == PH_HOME) begin
        if (home && magnitude(goal) > MOVE_MAG) begin
          ph       = PH_HIGH;
          step_cnt = '0;
          pos_cnt  = '0;
          goal     = reversed(goal);
        end
      end else begin
        if (step_cnt > spp) begin
          step_cnt = '0;
          if (goal > 0) pos_cnt = pos_cnt + 16'd1;
          else if (goal < 0 && pos_cnt > 16'd0) pos_cnt = pos_cnt - 16'd1;
        end
        if (ph == PH_HIGH && pos_cnt > high_pos) begin
          ph   = PH_LOW;
          goal = reversed(goal);
        end else if (ph == PH_LOW && pos_cnt < low_pos) begin
          ph   = PH_HIGH;
          goal = reversed(goal);
        end
      end

      gap = goal - speed;
      if (gap > 0) adj = (gap < acc) ? gap : acc;
      else if (gap < 0) adj = (gap > -acc) ? gap : -acc;

      if (adj != 0) begin
        speed  = speed + adj;
        tq_now = torque_for_speed();
        if (tq_now != tq_prev) begin
          if (tq_now == 8'd0 || tq_prev == 8'd0) cw = 1'b1;
          tq_prev = tq_now;
          tw      = 1'b1;
        end
      end
    endfunction

    function void note_item(kind_t k, logic home, logic [15:0] tgt_bits);
      motion_t     r;
      logic        tw, cw, pulse;
      int unsigned m, q;
      tw    = 1'b0;
      cw    = 1'b0;
      pulse = 1'b0;
      accepted++;
      case (k)
        K_TICK: accel_tick(home, tw, cw);
        K_STEP: begin
          if (magnitude(speed) > MOVE_MAG) begin
            pulse    = 1'b1;
            step_cnt = step_cnt + 16'd1;
          end
        end
        K_TARGET: goal = int'($signed(tgt_bits));
        default: begin
          goal   = 0;
          speed  = 0;
          tq_now = hold_tq;
          if (spp != 16'd0) begin
            step_cnt = '0;
            pos_cnt  = '0;
            ph       = PH_HOME;
          end
          cw = 1'b1;
        end
      endcase

      m = magnitude(speed);
      if (m < MIN_MAG) m = MIN_MAG;
      q = PERIOD_NUM / m;
      r.speed      = speed[15:0];
      r.period     = q[15:0];
      r.dir        = (speed > 0);
      r.torque     = tq_now;
      r.torque_wr  = tw;
      r.control_wr = cw;
      r.pos        = pos_cnt;
      r.phase      = ph;
      r.pulse      = pulse;
      r.goal       = goal[15:0];
      expected_q.push_back(r);
    endfunction

    function void cmp(string name, logic [15:0] e, logic [15:0] a);
      if (e !== a) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, e, a);
        errors++;
      end
    endfunction

    function void check_motion(logic [OUT_DW-1:0] d);
      motion_t e;
      if (expected_q.size() == 0) begin
        $error("result item with nothing outstanding: 0x%0h", d);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      cmp("motor_speed", e.speed, d[15:0]);
      cmp("step_period", e.period, d[31:16]);
      cmp("direction", e.dir, d[32]);
      cmp("torque", e.torque, d[40:33]);
      cmp("torque_write", e.torque_wr, d[41]);
      cmp("control_write", e.control_wr, d[42]);
      cmp("position_count", e.pos, d[58:43]);
      cmp("homing_phase", e.phase, d[60:59]);
      cmp("step_pulse", e.pulse, d[61]);
      cmp("target_speed", e.goal, d[77:62]);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata = '0;
  logic [1:0]          in_tuser = K_TICK;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_DW-1:0]   out_tdata;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]   cfg_paddr = '0;
  logic [CFG_DW-1:0]   cfg_pwdata = '0;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  motion_scoreboard sb = new();
  int               burst_left = 0;
  int               settings_run = 0;
  bit               timed_out = 1'b0;
  logic [31:0]      cyc = '0;
  int               rx_mode = 0;
  int               rx_left = 0;

  stepper_ramp_traverse_controller_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cyc <= cyc + 32'd1;
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(20, 150);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 9) == 0);
      default: out_tready <= (cyc[4:0] < 5'd20);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_item(kind_t'(in_tuser), in_tdata[0], in_tdata[16:1]);
      if (out_tvalid && out_tready) sb.check_motion(out_tdata);
    end
  end

  task automatic send_item(kind_t k, logic home, logic [15:0] tgt);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= {7'd0, tgt, home};
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {16'd0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, val);
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (sb.expected_q.size() != 0) begin
      $error("%0d results still outstanding", sb.expected_q.size());
      timed_out = 1'b1;
    end
  endtask

  task automatic apply_setting(int p);
    logic [15:0] v [8];
    case (p)
      0: begin
        v[0] = 16'(RST_HOLDING); v[1] = 16'(RST_MIN); v[2] = 16'(RST_MAX);
        v[3] = 16'(RST_DIV); v[4] = 16'(RST_ACCEL);
        v[5] = RST_LOW; v[6] = RST_HIGH; v[7] = RST_SPP;
      end
      1: begin
        v[0] = 16'd255; v[1] = 16'd255; v[2] = 16'd255; v[3] = 16'd0;
        v[4] = 16'd255; v[5] = 16'hFFFF; v[6] = 16'hFFFF; v[7] = 16'hFFFF;
      end
      2: begin
        foreach (v[i]) v[i] = 16'd0;
      end
      3: begin
        v[0] = 16'($urandom_range(0, 255)); v[1] = 16'd0; v[2] = 16'd255; v[3] = 16'd1;
        v[4] = 16'd1; v[5] = 16'd0; v[6] = 16'd0; v[7] = 16'd1;
      end
      7: begin
        v[0] = 16'($urandom_range(0, 255)); v[1] = 16'($urandom_range(0, 255));
        v[2] = 16'($urandom_range(0, 255)); v[3] = 16'($urandom_range(0, 255));
        v[4] = 16'($urandom_range(1, 255)); v[5] = 16'($urandom_range(0, 65535));
        v[6] = 16'($urandom_range(0, 65535)); v[7] = 16'd0;
      end
      default: begin
        v[0] = 16'($urandom_range(0, 255)); v[1] = 16'($urandom_range(0, 255));
        v[2] = 16'($urandom_range(0, 255));
        v[3] = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 255));
        v[4] = 16'($urandom_range(1, 64));
        v[5] = 16'($urandom_range(1, 3));
        v[6] = v[5] + 16'($urandom_range(1, 6));
        v[7] = 16'($urandom_range(1, 3));
      end
    endcase
    write_reg(R_HOLDING, v[0]);
    write_reg(R_MIN, v[1]);
    write_reg(R_MAX, v[2]);
    write_reg(R_DIV, v[3]);
    write_reg(R_ACCEL, v[4]);
    write_reg(R_LOW, v[5]);
    write_reg(R_HIGH, v[6]);
    write_reg(R_SPP, v[7]);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    settings_run++;
  endtask

  function automatic logic [15:0] random_target();
    int unsigned r;
    logic [15:0] t;
    r = $urandom_range(0, 9);
    if (r < 7) t = 16'($urandom_range(16, 3000));
    else if (r < 9) t = 16'($urandom);
    else t = 16'($urandom_range(0, 15));
    if ($urandom_range(0, 1)) t = -t;
    return t;
  endfunction

  task automatic random_items(int n);
    int unsigned r;
    send_item(K_TARGET, 1'($urandom_range(0, 1)), random_target());
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 45) send_item(K_STEP, 1'($urandom_range(0, 1)), 16'($urandom));
      else if (r < 93) send_item(K_TICK, ($urandom_range(0, 6) == 0), 16'($urandom));
      else if (r < 98) send_item(K_TARGET, 1'($urandom_range(0, 1)), random_target());
      else send_item(K_RESET, 1'($urandom_range(0, 1)), 16'($urandom));
    end
  endtask

  task automatic directed_items();
    send_item(K_TICK, 1'b0, 16'hFFFF);
    send_item(K_TICK, 1'b1, 16'h0000);
    send_item(K_TICK, 1'b1, 16'h5555);
    send_item(K_TARGET, 1'b1, 16'd20);
    repeat (3) send_item(K_TICK, 1'b0, 16'hAAAA);
    send_item(K_STEP, 1'b1, 16'hFFFF);
    send_item(K_TARGET, 1'b0, -16'd3);
    repeat (3) send_item(K_TICK, 1'b0, 16'h0000);
    send_item(K_STEP, 1'b0, 16'h0000);
    send_item(K_TARGET, 1'b0, 16'h7FFF);
    send_item(K_TARGET, 1'b1, 16'h8000);
    send_item(K_TICK, 1'b0, 16'h0000);
    send_item(K_TARGET, 1'b0, 16'h0000);
    send_item(K_TICK, 1'b0, 16'h0000);
    send_item(K_RESET, 1'b1, 16'hFFFF);
    send_item(K_TARGET, 1'b0, 16'hFFFF);
    send_item(K_TICK, 1'b0, 16'h0000);
    send_item(K_STEP, 1'b1, 16'h1234);
    send_item(K_RESET, 1'b0, 16'h0000);
  endtask

  // Drives the speed down to the most negative value, then homes so that the
  // saturated reversal of that target is taken.
  task automatic extreme_ramp();
    send_item(K_TARGET, 1'b0, 16'h8000);
    repeat (140) send_item(K_TICK, 1'b0, 16'($urandom));
    send_item(K_STEP, 1'b0, 16'($urandom));
    send_item(K_TICK, 1'b1, 16'($urandom));
    repeat (8) send_item(K_TICK, 1'b0, 16'($urandom));
    send_item(K_RESET, 1'b0, 16'($urandom));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int p = 0; p < 8; p++) begin
      apply_setting(p);
      if (p == 0) directed_items();
      if (p == 1) extreme_ramp();
      random_items((p == 1 || p == 2) ? 40 : 90);
      drain_results();
    end
    repeat (30) @(posedge clk);
    $display("Covered %0d items under %0d register settings in spool and traverse modes.",
             sb.accepted, settings_run);
    $display("Compared %0d results with %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0 && !timed_out && sb.expected_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
